/* rtl/lgsr_pkg.sv */
package lgsr_pkg;

	localparam int KIND_W  = 2;
	localparam int COORD_W = 8;
	localparam int CELL_W  = 32;
	localparam int SWEEP_W = 20;
	localparam int THR_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_INNER_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_CAP  = 2'd3;

	localparam logic [COORD_W-1:0]    RST_INNER_LOW  = 8'd25;
	localparam logic [COORD_W-1:0]    RST_INNER_HIGH = 8'd38;
	localparam logic [THR_W-1:0]      RST_THRESHOLD  = 16'd1;
	localparam logic [SWEEP_W-1:0]    RST_SWEEP_CAP  = 20'hFFFFF;

	// Address sources for the two memory read ports.
	typedef enum logic [2:0] {
		ADDR_IN,
		ADDR_ONE_ONE,
		ADDR_UP,
		ADDR_DOWN,
		ADDR_LEFT,
		ADDR_RIGHT
	} addr_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_ZERO,
		RES_READ,
		RES_SOLVE
	} res_t;

	typedef struct packed {
		addr_sel_t a_sel;
		addr_sel_t b_sel;
		logic      we_in;
		logic      we_cell;
		logic      cap_in;
		logic      ld_ud;
		logic      ld_lr;
		logic      ref_clr;
		logic      ref_ld;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      pos_clr;
		logic      pos_next;
		res_t      res;
		logic      conv;
	} dp_cmd_t;

	typedef struct packed {
		logic relax;
		logic col_last;
		logic row_last;
		logic gap_over;
		logic cap_hit;
	} dp_status_t;

endpackage

/* rtl/lgsr_datapath.sv */
module lgsr_datapath #(
	parameter int GRID_SIZE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lgsr_pkg::dp_cmd_t             cmd,
	output lgsr_pkg::dp_status_t          status,
	input  logic [lgsr_pkg::COORD_W-1:0]  row,
	input  logic [lgsr_pkg::COORD_W-1:0]  col,
	input  logic [lgsr_pkg::CELL_W-1:0]   cell_value,
	input  logic                          cfg_we,
	input  logic [lgsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgsr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          done,
	output logic [lgsr_pkg::CELL_W-1:0]   read_value,
	output logic [lgsr_pkg::SWEEP_W-1:0]  sweep_count,
	output logic                          converged
);
	import lgsr_pkg::*;

	localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ROW_W  = $clog2(GRID_SIZE);
	localparam logic [ROW_W-1:0] POS_FIRST = ROW_W'(1);
	localparam logic [ROW_W-1:0] POS_LAST  = ROW_W'(GRID_SIZE - 2);

	function automatic logic [ADDR_W-1:0] addr_of(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c);
		addr_of = ADDR_W'(ADDR_W'(r) * ADDR_W'(GRID_SIZE)) + ADDR_W'(c);
	endfunction

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rd_a_q, rd_b_q;

	logic [COORD_W-1:0] inner_low_q, inner_high_q;
	logic [THR_W-1:0]   threshold_q;
	logic [SWEEP_W-1:0] sweep_cap_q;
	logic [SWEEP_W-1:0] cnt_q, last_sweeps_q;
	logic               last_conv_q, done_q;

	logic [ROW_W-1:0]   r_q, c_q;
	logic [CELL_W-1:0]  ref_q, read_value_q;
	logic [CELL_W:0]    sum_ud_q, sum_lr_q;
	logic               inside_q;

	logic [ROW_W-1:0]   in_row, in_col, r_up, r_dn, c_lf, c_rt;
	logic               in_inside;
	logic [ADDR_W-1:0]  in_addr, cur_addr, addr_a, addr_b, waddr;
	logic               we;
	logic [CELL_W-1:0]  wdata, gap;
	logic [CELL_W+1:0]  total;
	logic [COORD_W-1:0] r8, c8;

	assign in_inside = ({1'b0, row} < (COORD_W+1)'(GRID_SIZE)) &&
	                   ({1'b0, col} < (COORD_W+1)'(GRID_SIZE));
	assign in_row = row[ROW_W-1:0];
	assign in_col = col[ROW_W-1:0];
	assign r_up = ROW_W'(r_q - POS_FIRST);
	assign r_dn = ROW_W'(r_q + POS_FIRST);
	assign c_lf = ROW_W'(c_q - POS_FIRST);
	assign c_rt = ROW_W'(c_q + POS_FIRST);
	assign in_addr  = addr_of(in_row, in_col);
	assign cur_addr = addr_of(r_q, c_q);

	function automatic logic [ADDR_W-1:0] pick(addr_sel_t s, logic [ADDR_W-1:0] a_in,
	                                           logic [ADDR_W-1:0] a_11, logic [ADDR_W-1:0] a_up,
	                                           logic [ADDR_W-1:0] a_dn, logic [ADDR_W-1:0] a_lf,
	                                           logic [ADDR_W-1:0] a_rt);
		unique case (s)
			ADDR_IN:      pick = a_in;
			ADDR_ONE_ONE: pick = a_11;
			ADDR_UP:      pick = a_up;
			ADDR_DOWN:    pick = a_dn;
			ADDR_LEFT:    pick = a_lf;
			ADDR_RIGHT:   pick = a_rt;
			default:      pick = a_in;
		endcase
	endfunction

	always_comb begin
		addr_a = pick(cmd.a_sel, in_addr, addr_of(POS_FIRST, POS_FIRST), addr_of(r_up, c_q),
		              addr_of(r_dn, c_q), addr_of(r_q, c_lf), addr_of(r_q, c_rt));
		addr_b = pick(cmd.b_sel, in_addr, addr_of(POS_FIRST, POS_FIRST), addr_of(r_up, c_q),
		              addr_of(r_dn, c_q), addr_of(r_q, c_lf), addr_of(r_q, c_rt));
	end

	// The neighbor sum is 34 bits wide; dropping two bits floors the average.
	assign total = (CELL_W+2)'(sum_ud_q) + (CELL_W+2)'(sum_lr_q);
	assign we    = (cmd.we_in && in_inside) || cmd.we_cell;
	assign waddr = cmd.we_cell ? cur_addr : in_addr;
	assign wdata = cmd.we_cell ? total[CELL_W+1:2] : cell_value;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	assign gap = (rd_a_q > ref_q) ? (rd_a_q - ref_q) : (ref_q - rd_a_q);
	assign r8  = COORD_W'(r_q);
	assign c8  = COORD_W'(c_q);

	assign status.relax    = (r8 >= inner_high_q) || (r8 <= inner_low_q) ||
	                         (c8 >= inner_high_q) || (c8 <= inner_low_q);
	assign status.col_last = (c_q == POS_LAST);
	assign status.row_last = (r_q == POS_LAST);
	assign status.gap_over = gap > CELL_W'(threshold_q);
	assign status.cap_hit  = cnt_q >= sweep_cap_q;

	always_ff @(posedge clk) begin
		if (cmd.ref_clr) begin
			ref_q <= '0;
		end else if (cmd.ref_ld) begin
			ref_q <= rd_a_q;
		end
		if (cmd.ld_ud) begin
			sum_ud_q <= (CELL_W+1)'(rd_a_q) + (CELL_W+1)'(rd_b_q);
		end
		if (cmd.ld_lr) begin
			sum_lr_q <= (CELL_W+1)'(rd_a_q) + (CELL_W+1)'(rd_b_q);
		end
		if (cmd.cap_in) begin
			inside_q <= in_inside;
		end
		if (cmd.res == RES_READ) begin
			read_value_q <= inside_q ? rd_a_q : '0;
		end else if (cmd.res != RES_NONE) begin
			read_value_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_low_q   <= RST_INNER_LOW;
			inner_high_q  <= RST_INNER_HIGH;
			threshold_q   <= RST_THRESHOLD;
			sweep_cap_q   <= RST_SWEEP_CAP;
			cnt_q         <= '0;
			last_sweeps_q <= '0;
			last_conv_q   <= 1'b0;
			done_q        <= 1'b0;
			r_q           <= POS_FIRST;
			c_q           <= POS_FIRST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INNER_LOW:  inner_low_q  <= cfg_data[COORD_W-1:0];
					CFG_INNER_HIGH: inner_high_q <= cfg_data[COORD_W-1:0];
					CFG_THRESHOLD:  threshold_q  <= cfg_data[THR_W-1:0];
					CFG_SWEEP_CAP:  sweep_cap_q  <= cfg_data[SWEEP_W-1:0];
					default:        ;
				endcase
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= SWEEP_W'(cnt_q + 1'b1);
			end
			if (cmd.pos_clr) begin
				r_q <= POS_FIRST;
				c_q <= POS_FIRST;
			end else if (cmd.pos_next) begin
				if (status.col_last) begin
					c_q <= POS_FIRST;
					r_q <= r_dn;
				end else begin
					c_q <= c_rt;
				end
			end
			if (cmd.res == RES_SOLVE) begin
				last_sweeps_q <= cnt_q;
				last_conv_q   <= cmd.conv;
			end
			done_q <= (cmd.res != RES_NONE);
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign sweep_count = last_sweeps_q;
	assign converged   = last_conv_q;

endmodule

/* rtl/lgsr_ctrl.sv */
module lgsr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lgsr_pkg::KIND_W-1:0]  kind,
	output logic                         busy,
	output lgsr_pkg::dp_cmd_t            cmd,
	input  lgsr_pkg::dp_status_t         status
);
	import lgsr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_WAIT,
		S_CHK_RD,
		S_CHK,
		S_CELL_A,
		S_CELL_B,
		S_CELL_C,
		S_CELL_D
	} state_t;

	state_t state_q;
	logic   sweep_end;

	assign sweep_end = status.col_last && status.row_last;
	assign busy      = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.a_sel = ADDR_IN;
		cmd.b_sel = ADDR_IN;
		cmd.res   = RES_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_WRITE: begin
							cmd.we_in = 1'b1;
							cmd.res   = RES_ZERO;
						end
						KIND_SOLVE: begin
							cmd.ref_clr = 1'b1;
							cmd.cnt_clr = 1'b1;
						end
						KIND_READ: cmd.cap_in = 1'b1;
						default:   cmd.res = RES_ZERO;
					endcase
				end
			end
			S_RD_WAIT: cmd.res = RES_READ;
			S_CHK_RD:  cmd.a_sel = ADDR_ONE_ONE;
			S_CHK: begin
				priority if (!status.gap_over) begin
					cmd.res  = RES_SOLVE;
					cmd.conv = 1'b1;
				end else if (status.cap_hit) begin
					cmd.res  = RES_SOLVE;
				end else begin
					cmd.ref_ld  = 1'b1;
					cmd.pos_clr = 1'b1;
				end
			end
			S_CELL_A: begin
				cmd.a_sel = ADDR_UP;
				cmd.b_sel = ADDR_DOWN;
				if (!status.relax) begin
					cmd.cnt_inc  = sweep_end;
					cmd.pos_next = !sweep_end;
				end
			end
			S_CELL_B: begin
				cmd.a_sel = ADDR_LEFT;
				cmd.b_sel = ADDR_RIGHT;
				cmd.ld_ud = 1'b1;
			end
			S_CELL_C: cmd.ld_lr = 1'b1;
			S_CELL_D: begin
				cmd.we_cell  = 1'b1;
				cmd.cnt_inc  = sweep_end;
				cmd.pos_next = !sweep_end;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (kind == KIND_SOLVE) begin
							state_q <= S_CHK_RD;
						end else if (kind == KIND_READ) begin
							state_q <= S_RD_WAIT;
						end
					end
				end
				S_RD_WAIT: state_q <= S_IDLE;
				S_CHK_RD:  state_q <= S_CHK;
				S_CHK: begin
					if (!status.gap_over || status.cap_hit) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CELL_A;
					end
				end
				S_CELL_A: begin
					if (status.relax) begin
						state_q <= S_CELL_B;
					end else if (sweep_end) begin
						state_q <= S_CHK_RD;
					end
				end
				S_CELL_B: state_q <= S_CELL_C;
				S_CELL_C: state_q <= S_CELL_D;
				S_CELL_D: state_q <= sweep_end ? S_CHK_RD : S_CELL_A;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/laplace_gauss_seidel_relaxation.sv */
// Five-point Laplace relaxation engine holding a GRID_SIZE x GRID_SIZE grid of
// unsigned Q16.16 potentials in a single memory with one write and two read
// ports. A request is taken when start is high and busy is low; every request
// yields exactly one result, shown on the result ports for one cycle while done
// is high, and the receiver cannot stall it. Write requests and unused kinds
// finish straight from idle; read requests pass a wait state for the registered
// memory read. A solve first checks cell (1,1) in S_CHK_RD and S_CHK, then each
// sweep steps through S_CELL_A to S_CELL_D per relaxed cell (neighbor reads over
// the two read ports, an add, and the write back) and through S_CELL_A alone per
// fixed cell, followed by another check; its result appears the cycle after the
// last check. Grid cells hold no reset value: a cell must be written before any
// read request or sweep uses it. Configuration writes are always ready and must
// only be issued while busy is low and no result is pending.
module laplace_gauss_seidel_relaxation #(
	parameter int GRID_SIZE = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [lgsr_pkg::KIND_W-1:0]     kind,
	input  logic [lgsr_pkg::COORD_W-1:0]    row,
	input  logic [lgsr_pkg::COORD_W-1:0]    col,
	input  logic [lgsr_pkg::CELL_W-1:0]     cell_value,
	output logic                            done,
	output logic [lgsr_pkg::CELL_W-1:0]     read_value,
	output logic [lgsr_pkg::SWEEP_W-1:0]    sweep_count,
	output logic                            converged,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lgsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lgsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lgsr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	lgsr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	lgsr_datapath #(
		.GRID_SIZE (GRID_SIZE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.row         (row),
		.col         (col),
		.cell_value  (cell_value),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.read_value  (read_value),
		.sweep_count (sweep_count),
		.converged   (converged)
	);

endmodule

/* sim/tb_laplace_gauss_seidel_relaxation.sv */
`timescale 1ns / 100ps

module tb_laplace_gauss_seidel_relaxation;
	import lgsr_pkg::*;

	localparam int GRID = 64;
	localparam int GRID_CELLS = GRID * GRID;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [CELL_W-1:0]  value;
		logic [SWEEP_W-1:0] sweeps;
		logic               conv;
	} cell_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [KIND_W-1:0]     kind = '0;
	logic [COORD_W-1:0]    row = '0;
	logic [COORD_W-1:0]    col = '0;
	logic [CELL_W-1:0]     cell_value = '0;
	logic                  done;
	logic [CELL_W-1:0]     read_value;
	logic [SWEEP_W-1:0]    sweep_count;
	logic                  converged;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Mirror of the block: grid, last solve outcome and registers.
	logic [CELL_W-1:0]  grid_mirror [GRID_CELLS];
	logic [SWEEP_W-1:0] last_sweeps;
	logic               last_conv;
	logic [COORD_W-1:0] fix_low;
	logic [COORD_W-1:0] fix_high;
	logic [THR_W-1:0]   tolerance;
	logic [SWEEP_W-1:0] sweep_limit;

	cell_result_t pending_results[$];

	bit sender_idles = 1'b1;
	int requests_sent = 0;
	int solves_sent = 0;
	int sweeps_predicted = 0;
	int register_writes = 0;
	int results_seen = 0;
	int mismatches = 0;

	laplace_gauss_seidel_relaxation #(
		.GRID_SIZE(GRID)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.row(row),
		.col(col),
		.cell_value(cell_value),
		.done(done),
		.read_value(read_value),
		.sweep_count(sweep_count),
		.converged(converged),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic void relax_sweep();
		logic [33:0] total;
		bit relax;
		for (int r = 1; r < GRID - 1; r++) begin
			for (int c = 1; c < GRID - 1; c++) begin
				relax = r >= fix_high || r <= fix_low || c >= fix_high || c <= fix_low;
				if (relax) begin
					total = 34'(grid_mirror[(r + 1) * GRID + c]) +
						34'(grid_mirror[(r - 1) * GRID + c]) +
						34'(grid_mirror[r * GRID + c + 1]) +
						34'(grid_mirror[r * GRID + c - 1]);
					grid_mirror[r * GRID + c] = total[33:2];
				end
			end
		end
	endfunction

	function automatic void run_relaxation();
		logic [CELL_W-1:0] anchor;
		logic [CELL_W-1:0] corner;
		logic [CELL_W-1:0] gap;
		int count;
		bit ok;
		anchor = '0;
		count = 0;
		ok = 1'b1;
		forever begin
			corner = grid_mirror[GRID + 1];
			gap = corner > anchor ? corner - anchor : anchor - corner;
			if (gap <= tolerance)
				break;
			if (count >= sweep_limit) begin
				ok = 1'b0;
				break;
			end
			anchor = corner;
			relax_sweep();
			count++;
		end
		sweeps_predicted += count;
		last_sweeps = SWEEP_W'(count);
		last_conv = ok;
	endfunction

	function automatic cell_result_t apply_request(input logic [KIND_W-1:0] k,
			input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
			input logic [CELL_W-1:0] v);
		cell_result_t res;
		bit in_grid;
		in_grid = r < GRID && c < GRID;
		res.value = '0;
		unique case (k)
			KIND_WRITE: begin
				if (in_grid)
					grid_mirror[r * GRID + c] = v;
			end
			KIND_SOLVE: begin
				run_relaxation();
			end
			KIND_READ: begin
				if (in_grid)
					res.value = grid_mirror[r * GRID + c];
			end
			default: ;
		endcase
		res.sweeps = last_sweeps;
		res.conv = last_conv;
		return res;
	endfunction

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: read_value %h sweep_count %0d converged %0b",
						read_value, sweep_count, converged);
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.value || sweep_count !== want.sweeps ||
						converged !== want.conv) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %h / %0d / %0b, got %h / %0d / %0b",
							results_seen, want.value, want.sweeps, want.conv,
							read_value, sweep_count, converged);
				end
			end
		end
	end

	// Start stays high after an accepted request; the next request or a pause
	// decides its value at the following falling edge.
	task automatic send_request(input logic [KIND_W-1:0] k, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic [CELL_W-1:0] v);
		@(negedge clk);
		while (sender_idles && $urandom_range(99) < 17) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		row <= r;
		col <= c;
		cell_value <= v;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_results.push_back(apply_request(k, r, c, v));
		requests_sent++;
		if (k == KIND_SOLVE)
			solves_sent++;
	endtask

	task automatic pause_requests();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		unique case (idx)
			CFG_INNER_LOW:  fix_low = data[COORD_W-1:0];
			CFG_INNER_HIGH: fix_high = data[COORD_W-1:0];
			CFG_THRESHOLD:  tolerance = data[THR_W-1:0];
			CFG_SWEEP_CAP:  sweep_limit = data[SWEEP_W-1:0];
			default: ;
		endcase
		register_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return COORD_W'($urandom_range(GRID, 255));
		if (roll < 30)
			return COORD_W'($urandom_range(0, 2));
		return COORD_W'($urandom_range(0, GRID - 1));
	endfunction

	function automatic logic [CELL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 10)
			return '1;
		if (roll < 40)
			return CELL_W'($urandom_range(0, 65535));
		return CELL_W'($urandom());
	endfunction

	task automatic fill_grid(input bit scramble, input logic [CELL_W-1:0] level);
		for (int r = 0; r < GRID; r++)
			for (int c = 0; c < GRID; c++)
				send_request(KIND_WRITE, COORD_W'(r), COORD_W'(c),
					scramble ? pick_value() : level);
	endtask

	// Before the grid is filled, only cells written here are read back.
	task automatic test_basic_access();
		send_request(KIND_READ, 8'd255, 8'd255, '0);
		send_request(KIND_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF);
		send_request(KIND_READ, 8'd0, 8'd0, '0);
		send_request(KIND_WRITE, 8'd63, 8'd63, '0);
		send_request(KIND_READ, 8'd63, 8'd63, 32'hFFFF_FFFF);
		send_request(KIND_WRITE, 8'd64, 8'd0, 32'h1234_5678);
		send_request(KIND_WRITE, 8'd0, 8'd255, 32'h8765_4321);
		send_request(KIND_READ, 8'd64, 8'd0, '0);
		send_request(KIND_READ, 8'd0, 8'd64, '0);
		send_request(KIND_UNUSED, 8'd255, 8'd255, 32'hFFFF_FFFF);
		send_request(KIND_WRITE, 8'd1, 8'd1, '0);
		send_request(KIND_SOLVE, 8'd0, 8'd0, '0);
		send_request(KIND_READ, 8'd1, 8'd1, '0);
	endtask

	// An all-ones grid makes the neighbor sum overflow 32 bits.
	task automatic test_uniform_fill();
		fill_grid(1'b0, 32'hFFFF_FFFF);
		send_request(KIND_SOLVE, 8'd0, 8'd0, '0);
		send_request(KIND_READ, 8'd1, 8'd1, '0);
		send_request(KIND_READ, 8'd40, 8'd40, '0);
	endtask

	task automatic test_solve_limits();
		pause_requests();
		write_register(CFG_SWEEP_CAP, '0);
		send_request(KIND_WRITE, 8'd1, 8'd1, 32'd5);
		send_request(KIND_SOLVE, 8'd0, 8'd0, '0);
		pause_requests();
		write_register(CFG_SWEEP_CAP, 20'd1);
		send_request(KIND_WRITE, 8'd1, 8'd1, 32'd100);
		send_request(KIND_SOLVE, 8'd0, 8'd0, '0);
		send_request(KIND_READ, 8'd1, 8'd1, '0);
	endtask

	task automatic test_register_extremes();
		// Every interior cell fixed: one sweep leaves (1,1) alone and the solve settles.
		pause_requests();
		write_register(CFG_INNER_LOW, '0);
		write_register(CFG_INNER_HIGH, 20'd255);
		write_register(CFG_THRESHOLD, '0);
		write_register(CFG_SWEEP_CAP, 20'hFFFFF);
		send_request(KIND_WRITE, 8'd1, 8'd1, 32'd7);
		send_request(KIND_SOLVE, 8'd0, 8'd0, '0);
		send_request(KIND_READ, 8'd1, 8'd1, '0);
		// Empty inner square: every interior cell relaxes.
		pause_requests();
		write_register(CFG_INNER_LOW, 20'd255);
		write_register(CFG_INNER_HIGH, '0);
		write_register(CFG_THRESHOLD, 20'hFFFF);
		write_register(CFG_SWEEP_CAP, 20'd2);
		send_request(KIND_WRITE, 8'd1, 8'd1, 32'd20000);
		send_request(KIND_WRITE, 8'd30, 8'd30, '0);
		send_request(KIND_SOLVE, 8'd0, 8'd0, '0);
		send_request(KIND_READ, 8'd30, 8'd30, '0);
		pause_requests();
		write_register(CFG_SWEEP_CAP, 20'hFFFFF);
		send_request(KIND_WRITE, 8'd1, 8'd1, 32'hFFFF);
		send_request(KIND_SOLVE, 8'd0, 8'd0, '0);
	endtask

	task automatic test_random_traffic();
		int roll;
		int solves_left;
		solves_left = 16;
		fill_grid(1'b1, '0);
		for (int seg = 0; seg < 8; seg++) begin
			pause_requests();
			write_register(CFG_INNER_LOW, CFG_DATA_W'($urandom()));
			write_register(CFG_INNER_HIGH, CFG_DATA_W'($urandom()));
			write_register(CFG_THRESHOLD, $urandom_range(1) ?
				CFG_DATA_W'($urandom()) : CFG_DATA_W'($urandom_range(0, 15)));
			write_register(CFG_SWEEP_CAP, CFG_DATA_W'($urandom_range(0, 2)));
			sender_idles = seg != 3;
			for (int n = 0; n < 100; n++) begin
				roll = $urandom_range(99);
				if (roll < 2 && solves_left > 0) begin
					send_request(KIND_SOLVE, COORD_W'($urandom()), COORD_W'($urandom()),
						CELL_W'($urandom()));
					solves_left--;
				end else if (roll < 5) begin
					send_request(KIND_UNUSED, COORD_W'($urandom()), COORD_W'($urandom()),
						CELL_W'($urandom()));
				end else if (roll < 50) begin
					send_request(KIND_WRITE, pick_coord(), pick_coord(), pick_value());
				end else begin
					send_request(KIND_READ, pick_coord(), pick_coord(), CELL_W'($urandom()));
				end
				if ($urandom_range(199) == 0)
					pause_requests();
			end
		end
		sender_idles = 1'b1;
	endtask

	initial begin
		last_sweeps = '0;
		last_conv = 1'b0;
		fix_low = RST_INNER_LOW;
		fix_high = RST_INNER_HIGH;
		tolerance = RST_THRESHOLD;
		sweep_limit = RST_SWEEP_CAP;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_access();
		test_uniform_fill();
		test_solve_limits();
		test_register_extremes();
		test_random_traffic();

		pause_requests();
		repeat (50) @(posedge clk);
		mismatches += pending_results.size();
		$display("sent %0d requests (%0d solves, %0d sweeps predicted), %0d register writes",
			requests_sent, solves_sent, sweeps_predicted, register_writes);
		$display("compared %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
